>>> src/tesp_pkg.sv
// Shared types, widths and constants for the two-axis encoder position stop block.
package tesp_pkg;

  localparam int POS_BITS  = 16;
  localparam int FRAC_BITS = 8;
  localparam int DEST_W    = 24;
  localparam int SPM_W     = 10;
  localparam int LIMIT_W   = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;

  // dest (signed) times steps/mm (unsigned, one extra sign bit)
  localparam int PROD_W  = DEST_W + SPM_W + 1;
  localparam int SHPOS_W = POS_BITS + FRAC_BITS;
  localparam int SUM_W   = ((PROD_W > SHPOS_W) ? PROD_W : SHPOS_W) + 2;
  localparam int STEP_W  = SUM_W - FRAC_BITS;

  localparam logic [SPM_W-1:0]   SPM_RESET   = SPM_W'(80);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32767);

  typedef enum logic [1:0] {
    REQ_MOVE = 2'd0,
    REQ_TICK = 2'd1,
    REQ_STOP = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ABS_MODE = 2'd0,
    CFG_X_SPM    = 2'd1,
    CFG_Y_SPM    = 2'd2,
    CFG_X_LIMIT  = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    DRV_BRAKE = 2'd0,
    DRV_FWD   = 2'd1,
    DRV_BACK  = 2'd2
  } drive_e;

  typedef enum logic [1:0] {
    ARM_NONE = 2'd0,
    ARM_A    = 2'd1,
    ARM_B    = 2'd2
  } arm_e;

  // One update for one axis, valid only in the cycle the item is applied.
  typedef struct packed {
    logic                       move;
    logic                       goal_wr;
    logic signed [POS_BITS-1:0] goal;
    logic                       tick;
    logic                       chan;
    logic                       stop;
  } axis_cmd_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] pos;
    drive_e                     drive;
    logic                       busy;
  } axis_stat_t;

endpackage

>>> src/tesp_conv.sv
// Millimetre-to-step conversion: adds the position offset in relative mode and truncates toward zero.
module tesp_conv (
  input  logic signed [tesp_pkg::PROD_W-1:0]   prod_i,
  input  logic signed [tesp_pkg::POS_BITS-1:0] pos_i,
  input  logic                                 absolute_i,
  output logic signed [tesp_pkg::STEP_W-1:0]   steps_o
);

  logic signed [tesp_pkg::SUM_W-1:0] offset;
  logic signed [tesp_pkg::SUM_W-1:0] sum;
  logic signed [tesp_pkg::SUM_W-1:0] biased;
  logic [tesp_pkg::SUM_W-1:0]        bias;

  always_comb begin
    offset = absolute_i ? '0
                        : (tesp_pkg::SUM_W'(pos_i) <<< tesp_pkg::FRAC_BITS);
    sum    = tesp_pkg::SUM_W'(prod_i) + offset;
    // negative values round toward zero: add 2^F - 1 before the shift
    bias   = sum[tesp_pkg::SUM_W-1]
           ? ((tesp_pkg::SUM_W'(1) << tesp_pkg::FRAC_BITS) - tesp_pkg::SUM_W'(1))
           : '0;
    biased = sum + $signed(bias);
    steps_o = biased[tesp_pkg::SUM_W-1:tesp_pkg::FRAC_BITS];
  end

endmodule

>>> src/tesp_axis.sv
// One axis: position counter, goal, armed channel, moving flag and bridge state.
module tesp_axis (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tesp_pkg::axis_cmd_t   cmd_i,
  output tesp_pkg::axis_stat_t  stat_o
);

  logic signed [tesp_pkg::POS_BITS-1:0] pos_q, pos_d;
  logic signed [tesp_pkg::POS_BITS-1:0] goal_q, goal_d;
  logic                                 busy_q, busy_d;
  tesp_pkg::arm_e                       arm_q, arm_d;
  tesp_pkg::drive_e                     drive_q, drive_d;

  logic signed [tesp_pkg::POS_BITS-1:0] goal_eff;
  logic                                 counted;

  always_comb begin
    pos_d   = pos_q;
    goal_d  = goal_q;
    busy_d  = busy_q;
    arm_d   = arm_q;
    drive_d = drive_q;
    counted = 1'b0;
    goal_eff = cmd_i.goal_wr ? cmd_i.goal : goal_q;

    if (cmd_i.move) begin
      goal_d = goal_eff;
      if (goal_eff > pos_q) begin
        busy_d  = 1'b1;
        arm_d   = tesp_pkg::ARM_A;
        drive_d = tesp_pkg::DRV_FWD;
      end else if (goal_eff < pos_q) begin
        busy_d  = 1'b1;
        arm_d   = tesp_pkg::ARM_B;
        drive_d = tesp_pkg::DRV_BACK;
      end
    end

    if (cmd_i.tick) begin
      if (arm_q == tesp_pkg::ARM_A && !cmd_i.chan) begin
        pos_d   = pos_q + tesp_pkg::POS_BITS'(1);
        counted = 1'b1;
      end else if (arm_q == tesp_pkg::ARM_B && cmd_i.chan) begin
        pos_d   = pos_q - tesp_pkg::POS_BITS'(1);
        counted = 1'b1;
      end
      if (counted && pos_d == goal_q) begin
        drive_d = tesp_pkg::DRV_BRAKE;
        busy_d  = 1'b0;
      end
    end

    if (cmd_i.stop) begin
      arm_d   = tesp_pkg::ARM_NONE;
      busy_d  = 1'b0;
      drive_d = tesp_pkg::DRV_BRAKE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      goal_q  <= '0;
      busy_q  <= 1'b0;
      arm_q   <= tesp_pkg::ARM_NONE;
      drive_q <= tesp_pkg::DRV_BRAKE;
    end else begin
      pos_q   <= pos_d;
      goal_q  <= goal_d;
      busy_q  <= busy_d;
      arm_q   <= arm_d;
      drive_q <= drive_d;
    end
  end

  assign stat_o.pos   = pos_q;
  assign stat_o.drive = drive_q;
  assign stat_o.busy  = busy_q;

endmodule

>>> src/two_axis_encoder_position_stop.sv
// Top level: input register with the step products, axis update, result handshake.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | into      | in_valid_i / in_ready_o    | req_type, axis, channel, use_x/y, dest
//  out     | out of    | out_valid_o / out_ready_i  | drives, busy flags, positions
//  cfg     | into      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// An item is first taken into the input register together with the
// dest * steps_per_mm products; the axis update then adds the position offset,
// checks the X range or saturates Y, and updates the axis state. The axis state
// registers are the result; one item per cycle is sustained while results are taken.
// A stalled result holds the axis state; one more item waits in the input
// register. Reset brakes both axes, clears positions, goals and arming, and
// loads the register defaults (relative mode, 80 steps/mm, limit 32767).
module two_axis_encoder_position_stop (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           req_type_i,
  input  logic                                 axis_i,
  input  logic                                 channel_i,
  input  logic                                 use_x_i,
  input  logic                                 use_y_i,
  input  logic signed [tesp_pkg::DEST_W-1:0]   dest_x_mm_i,
  input  logic signed [tesp_pkg::DEST_W-1:0]   dest_y_mm_i,

  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           x_drive_o,
  output logic [1:0]                           y_drive_o,
  output logic                                 x_busy_o,
  output logic                                 y_busy_o,
  output logic                                 any_busy_o,
  output logic signed [tesp_pkg::POS_BITS-1:0] x_position_o,
  output logic signed [tesp_pkg::POS_BITS-1:0] y_position_o,

  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tesp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tesp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int SW = tesp_pkg::STEP_W;
  localparam logic signed [SW-1:0] POS_MAX_W = SW'((2 ** (tesp_pkg::POS_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] POS_MIN_W = -POS_MAX_W - SW'(1);

  // configuration registers
  logic                                abs_q;
  logic [tesp_pkg::SPM_W-1:0]          x_spm_q, y_spm_q;
  logic [tesp_pkg::LIMIT_W-1:0]        x_limit_q;

  // input register
  logic                                s1_valid_q;
  logic [1:0]                          s1_req_q;
  logic                                s1_axis_q, s1_ch_q, s1_use_x_q, s1_use_y_q;
  logic signed [tesp_pkg::PROD_W-1:0]  s1_prod_x_q, s1_prod_y_q;
  logic signed [tesp_pkg::PROD_W-1:0]  prod_x_d, prod_y_d;

  logic                                out_valid_q;
  logic                                s1_adv, in_acc;

  logic signed [SW-1:0]                steps_x, steps_y;
  logic                                x_ok;
  logic signed [tesp_pkg::POS_BITS-1:0] y_goal;

  tesp_pkg::axis_cmd_t                 x_cmd, y_cmd;
  tesp_pkg::axis_stat_t                x_stat, y_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_q     <= 1'b0;
      x_spm_q   <= tesp_pkg::SPM_RESET;
      y_spm_q   <= tesp_pkg::SPM_RESET;
      x_limit_q <= tesp_pkg::LIMIT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tesp_pkg::CFG_ABS_MODE: abs_q     <= cfg_data_i[0];
        tesp_pkg::CFG_X_SPM:    x_spm_q   <= cfg_data_i[tesp_pkg::SPM_W-1:0];
        tesp_pkg::CFG_Y_SPM:    y_spm_q   <= cfg_data_i[tesp_pkg::SPM_W-1:0];
        tesp_pkg::CFG_X_LIMIT:  x_limit_q <= cfg_data_i[tesp_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the axis state is the result register
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // multiply at input; user must keep config stable while items are in flight (not enforced)
  assign prod_x_d = dest_x_mm_i * $signed({1'b0, x_spm_q});
  assign prod_y_d = dest_y_mm_i * $signed({1'b0, y_spm_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q    <= req_type_i;
      s1_axis_q   <= axis_i;
      s1_ch_q     <= channel_i;
      s1_use_x_q  <= use_x_i;
      s1_use_y_q  <= use_y_i;
      s1_prod_x_q <= prod_x_d;
      s1_prod_y_q <= prod_y_d;
    end
  end

  tesp_conv u_conv_x (
    .prod_i     (s1_prod_x_q),
    .pos_i      (x_stat.pos),
    .absolute_i (abs_q),
    .steps_o    (steps_x)
  );

  tesp_conv u_conv_y (
    .prod_i     (s1_prod_y_q),
    .pos_i      (y_stat.pos),
    .absolute_i (abs_q),
    .steps_o    (steps_y)
  );

  // X target outside the travel range leaves the old goal in place
  assign x_ok = (steps_x >= 0) && (steps_x < $signed(SW'(x_limit_q)))
             && (steps_x <= POS_MAX_W);

  // Y target clamps to the position range
  always_comb begin
    if (steps_y > POS_MAX_W) begin
      y_goal = POS_MAX_W[tesp_pkg::POS_BITS-1:0];
    end else if (steps_y < POS_MIN_W) begin
      y_goal = POS_MIN_W[tesp_pkg::POS_BITS-1:0];
    end else begin
      y_goal = steps_y[tesp_pkg::POS_BITS-1:0];
    end
  end

  always_comb begin
    x_cmd = '0;
    y_cmd = '0;
    x_cmd.goal = steps_x[tesp_pkg::POS_BITS-1:0];
    y_cmd.goal = y_goal;
    x_cmd.chan = s1_ch_q;
    y_cmd.chan = s1_ch_q;
    if (s1_adv) begin
      case (s1_req_q)
        tesp_pkg::REQ_MOVE: begin
          x_cmd.move    = s1_use_x_q;
          x_cmd.goal_wr = s1_use_x_q && x_ok;
          y_cmd.move    = s1_use_y_q;
          y_cmd.goal_wr = s1_use_y_q;
        end
        tesp_pkg::REQ_TICK: begin
          x_cmd.tick = !s1_axis_q;
          y_cmd.tick = s1_axis_q;
        end
        tesp_pkg::REQ_STOP: begin
          x_cmd.stop = !s1_axis_q;
          y_cmd.stop = s1_axis_q;
        end
        default: ;  // unused code: report state unchanged
      endcase
    end
  end

  tesp_axis u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (x_cmd),
    .stat_o (x_stat)
  );

  tesp_axis u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (y_cmd),
    .stat_o (y_stat)
  );

  assign out_valid_o  = out_valid_q;
  assign x_drive_o    = x_stat.drive;
  assign y_drive_o    = y_stat.drive;
  assign x_busy_o     = x_stat.busy;
  assign y_busy_o     = y_stat.busy;
  assign any_busy_o   = x_stat.busy || y_stat.busy;
  assign x_position_o = x_stat.pos;
  assign y_position_o = y_stat.pos;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the two-axis encoder position stop block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code the block does not define; it must leave all state alone.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic       AXIS_X     = 1'b0;
  localparam logic       AXIS_Y     = 1'b1;
  localparam logic       CH_A       = 1'b0;
  localparam logic       CH_B       = 1'b1;

  localparam longint POS_MAX    = (longint'(1) <<< (tesp_pkg::POS_BITS - 1)) - 1;
  localparam longint POS_MIN    = -POS_MAX - 1;
  localparam longint DEST_MAX   = (longint'(1) <<< (tesp_pkg::DEST_W - 1)) - 1;
  localparam longint DEST_MIN   = -DEST_MAX - 1;
  localparam longint FRAC_SCALE = longint'(1) <<< tesp_pkg::FRAC_BITS;

  // Per-axis shadow of the block's state.
  typedef struct {
    logic signed [tesp_pkg::POS_BITS-1:0] pos;
    logic signed [tesp_pkg::POS_BITS-1:0] goal;
    logic                                 moving;
    tesp_pkg::arm_e                       armed;
    tesp_pkg::drive_e                     bridge;
  } axis_model_t;

  // One result item as the block should present it.
  typedef struct {
    logic [1:0]                           x_drive;
    logic [1:0]                           y_drive;
    logic                                 x_busy;
    logic                                 y_busy;
    logic                                 any_busy;
    logic signed [tesp_pkg::POS_BITS-1:0] x_pos;
    logic signed [tesp_pkg::POS_BITS-1:0] y_pos;
  } status_t;

  // ---------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // ---------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                                 in_valid_i  = 1'b0;
  logic                                 in_ready_o;
  logic [1:0]                           req_type_i  = '0;
  logic                                 axis_i      = 1'b0;
  logic                                 channel_i   = 1'b0;
  logic                                 use_x_i     = 1'b0;
  logic                                 use_y_i     = 1'b0;
  logic signed [tesp_pkg::DEST_W-1:0]   dest_x_mm_i = '0;
  logic signed [tesp_pkg::DEST_W-1:0]   dest_y_mm_i = '0;

  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic [1:0]                           x_drive_o;
  logic [1:0]                           y_drive_o;
  logic                                 x_busy_o;
  logic                                 y_busy_o;
  logic                                 any_busy_o;
  logic signed [tesp_pkg::POS_BITS-1:0] x_position_o;
  logic signed [tesp_pkg::POS_BITS-1:0] y_position_o;

  logic                                 cfg_valid_i = 1'b0;
  logic                                 cfg_ready_o;
  logic [tesp_pkg::CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [tesp_pkg::CFG_DATA_W-1:0]      cfg_data_i  = '0;

  // Shadow registers, loaded with the reset defaults.
  logic                           abs_mode = 1'b0;
  logic [tesp_pkg::SPM_W-1:0]     x_spm    = tesp_pkg::SPM_RESET;
  logic [tesp_pkg::SPM_W-1:0]     y_spm    = tesp_pkg::SPM_RESET;
  logic [tesp_pkg::LIMIT_W-1:0]   x_limit  = tesp_pkg::LIMIT_RESET;
  axis_model_t                    axes[2];

  status_t     status_expected_q[$];
  int          mismatches     = 0;
  int          items_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  two_axis_encoder_position_stop dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .axis_i       (axis_i),
    .channel_i    (channel_i),
    .use_x_i      (use_x_i),
    .use_y_i      (use_y_i),
    .dest_x_mm_i  (dest_x_mm_i),
    .dest_y_mm_i  (dest_y_mm_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .x_drive_o    (x_drive_o),
    .y_drive_o    (y_drive_o),
    .x_busy_o     (x_busy_o),
    .y_busy_o     (y_busy_o),
    .any_busy_o   (any_busy_o),
    .x_position_o (x_position_o),
    .y_position_o (y_position_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic coin();
    return logic'($urandom_range(1));
  endfunction

  // mm (fixed point) to whole steps; relative mode adds the current
  // position first. SV integer division truncates toward zero, which is
  // exactly the rounding the block uses.
  function automatic longint mm_to_steps(logic idx, logic signed [tesp_pkg::DEST_W-1:0] dest,
                                         logic [tesp_pkg::SPM_W-1:0] spm);
    longint scaled;
    scaled = longint'(dest) * longint'(spm);
    if (!abs_mode) scaled += longint'(axes[idx].pos) * FRAC_SCALE;
    return scaled / FRAC_SCALE;
  endfunction

  // Pick a direction against the goal; an axis already on goal is untouched.
  function automatic void steer_axis(logic idx);
    if (axes[idx].goal > axes[idx].pos) begin
      axes[idx].moving = 1'b1;
      axes[idx].armed  = tesp_pkg::ARM_A;
      axes[idx].bridge = tesp_pkg::DRV_FWD;
    end else if (axes[idx].goal < axes[idx].pos) begin
      axes[idx].moving = 1'b1;
      axes[idx].armed  = tesp_pkg::ARM_B;
      axes[idx].bridge = tesp_pkg::DRV_BACK;
    end
  endfunction

  // Apply one accepted item to the shadow state and return the status the
  // block should report for it.
  function automatic status_t advance_axes(logic [1:0] req, logic ax, logic ch,
                                           logic ux, logic uy,
                                           logic signed [tesp_pkg::DEST_W-1:0] dx,
                                           logic signed [tesp_pkg::DEST_W-1:0] dy);
    longint  t;
    logic    counted;
    status_t s;
    case (req)
      tesp_pkg::REQ_MOVE: begin
        if (ux) begin
          // Out-of-range X targets are dropped; the old goal still steers.
          t = mm_to_steps(AXIS_X, dx, x_spm);
          if (t >= 0 && t < longint'(x_limit) && t <= POS_MAX)
            axes[AXIS_X].goal = t[tesp_pkg::POS_BITS-1:0];
          steer_axis(AXIS_X);
        end
        if (uy) begin
          // Y targets clamp to the position range.
          t = mm_to_steps(AXIS_Y, dy, y_spm);
          if (t > POS_MAX) t = POS_MAX;
          else if (t < POS_MIN) t = POS_MIN;
          axes[AXIS_Y].goal = t[tesp_pkg::POS_BITS-1:0];
          steer_axis(AXIS_Y);
        end
      end
      tesp_pkg::REQ_TICK: begin
        // Only the channel armed for the direction counts; wraps at 16 bits.
        counted = 1'b1;
        if (axes[ax].armed == tesp_pkg::ARM_A && ch == CH_A)
          axes[ax].pos = axes[ax].pos + 1'b1;
        else if (axes[ax].armed == tesp_pkg::ARM_B && ch == CH_B)
          axes[ax].pos = axes[ax].pos - 1'b1;
        else counted = 1'b0;
        if (counted && axes[ax].pos == axes[ax].goal) begin
          axes[ax].bridge = tesp_pkg::DRV_BRAKE;
          axes[ax].moving = 1'b0;
        end
      end
      tesp_pkg::REQ_STOP: begin
        axes[ax].armed  = tesp_pkg::ARM_NONE;
        axes[ax].moving = 1'b0;
        axes[ax].bridge = tesp_pkg::DRV_BRAKE;
      end
      default: ;
    endcase
    s.x_drive  = axes[AXIS_X].bridge;
    s.y_drive  = axes[AXIS_Y].bridge;
    s.x_busy   = axes[AXIS_X].moving;
    s.y_busy   = axes[AXIS_Y].moving;
    s.any_busy = axes[AXIS_X].moving | axes[AXIS_Y].moving;
    s.x_pos    = axes[AXIS_X].pos;
    s.y_pos    = axes[AXIS_Y].pos;
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random backpressure and the scoreboard check.
  // ---------------------------------------------------------------------

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endfunction

  // Values are read in the active region right after the edge, so they are
  // the ones the block presented at that edge.
  always @(posedge clk_i) begin : check_results
    status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_expected_q.size() == 0) begin
        $error("result item arrived with nothing expected");
        mismatches++;
      end else begin
        want = status_expected_q.pop_front();
        compare_field("x_drive",    want.x_drive,  x_drive_o);
        compare_field("y_drive",    want.y_drive,  y_drive_o);
        compare_field("x_busy",     want.x_busy,   x_busy_o);
        compare_field("y_busy",     want.y_busy,   y_busy_o);
        compare_field("any_busy",   want.any_busy, any_busy_o);
        compare_field("x_position", want.x_pos,    x_position_o);
        compare_field("y_position", want.y_pos,    y_position_o);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Item and register drivers. All tasks return right after a rising edge.
  // ---------------------------------------------------------------------

  // Send one item. Valid is left high on return so back-to-back items do
  // not toggle it within a time step; idle gaps lower it.
  task automatic issue_request(logic [1:0] req, logic ax, logic ch, logic ux, logic uy,
                               logic signed [tesp_pkg::DEST_W-1:0] dx,
                               logic signed [tesp_pkg::DEST_W-1:0] dy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    axis_i      <= ax;
    channel_i   <= ch;
    use_x_i     <= ux;
    use_y_i     <= uy;
    dest_x_mm_i <= dx;
    dest_y_mm_i <= dy;
    do @(posedge clk_i); while (!in_ready_o);
    status_expected_q.push_back(advance_axes(req, ax, ch, ux, uy, dx, dy));
    items_sent++;
  endtask

  // Every item yields a result, so an empty queue means the block is idle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (status_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(tesp_pkg::cfg_e idx, logic [tesp_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tesp_pkg::CFG_ABS_MODE: abs_mode = data[0];
      tesp_pkg::CFG_X_SPM:    x_spm    = data[tesp_pkg::SPM_W-1:0];
      tesp_pkg::CFG_Y_SPM:    y_spm    = data[tesp_pkg::SPM_W-1:0];
      tesp_pkg::CFG_X_LIMIT:  x_limit  = data[tesp_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Full register load while idle; bits above a register's width are junk.
  task automatic load_settings(logic [tesp_pkg::CFG_DATA_W-1:0] mode_word,
                               logic [tesp_pkg::CFG_DATA_W-1:0] xspm_word,
                               logic [tesp_pkg::CFG_DATA_W-1:0] yspm_word,
                               logic [tesp_pkg::CFG_DATA_W-1:0] limit_word);
    drain_results();
    write_register(tesp_pkg::CFG_ABS_MODE, mode_word);
    write_register(tesp_pkg::CFG_X_SPM,    xspm_word);
    write_register(tesp_pkg::CFG_Y_SPM,    yspm_word);
    write_register(tesp_pkg::CFG_X_LIMIT,  limit_word);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Target a few steps from the current position so that an encoder
  // sequence can actually reach it; now and then anything at all.
  function automatic logic signed [tesp_pkg::DEST_W-1:0] pick_dest(
      logic idx, logic [tesp_pkg::SPM_W-1:0] spm);
    longint span;
    longint d;
    if (spm == 0 || $urandom_range(9) == 0) return tesp_pkg::DEST_W'($urandom);
    span = (6 * FRAC_SCALE) / longint'(spm) + 1;
    if (abs_mode)
      d = (longint'(axes[idx].pos) + longint'($urandom_range(12)) - 6) * FRAC_SCALE
          / longint'(spm);
    else
      d = longint'($urandom_range(2 * span)) - span;
    if (d > DEST_MAX) d = DEST_MAX;
    if (d < DEST_MIN) d = DEST_MIN;
    return d[tesp_pkg::DEST_W-1:0];
  endfunction

  // Defaults after reset: relative, 80 steps/mm, limit 32767.
  task automatic test_corner_requests();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // undefined request code with targets attached: nothing moves
    issue_request(REQ_UNUSED, AXIS_X, CH_A, 1'b1, 1'b1, 24'sh7FFFFF, 24'sh7FFFFF);
    issue_request(tesp_pkg::REQ_TICK, AXIS_X, CH_A, 1'b0, 1'b0, '0, '0);    // nothing armed
    issue_request(tesp_pkg::REQ_STOP, AXIS_X, CH_B, 1'b0, 1'b0, '0, '0);
    issue_request(tesp_pkg::REQ_MOVE, AXIS_Y, CH_B, 1'b1, 1'b0, 24'sd4, '0); // 1 step forward
    issue_request(tesp_pkg::REQ_TICK, AXIS_X, CH_B, 1'b0, 1'b0, '0, '0);    // wrong channel
    issue_request(tesp_pkg::REQ_TICK, AXIS_X, CH_A, 1'b0, 1'b0, '0, '0);    // on goal: brake
    issue_request(tesp_pkg::REQ_TICK, AXIS_X, CH_A, 1'b0, 1'b0, '0, '0);    // counts past goal
    // negative X target: rejected, old goal pulls the axis back
    issue_request(tesp_pkg::REQ_MOVE, AXIS_X, CH_A, 1'b1, 1'b0, -24'sd32, '0);
    issue_request(tesp_pkg::REQ_TICK, AXIS_X, CH_B, 1'b0, 1'b0, '0, '0);
    issue_request(tesp_pkg::REQ_MOVE, AXIS_X, CH_A, 1'b1, 1'b0, '0, '0);    // already there
    // beyond the travel limit
    issue_request(tesp_pkg::REQ_MOVE, AXIS_X, CH_A, 1'b1, 1'b0, 24'sh7FFFFF, '0);
    // Y saturates at both ends of the position range
    issue_request(tesp_pkg::REQ_MOVE, AXIS_X, CH_A, 1'b0, 1'b1, '0, 24'sh7FFFFF);
    issue_request(tesp_pkg::REQ_MOVE, AXIS_X, CH_A, 1'b0, 1'b1, '0, 24'sh800000);
    issue_request(tesp_pkg::REQ_TICK, AXIS_Y, CH_B, 1'b0, 1'b0, '0, '0);
    issue_request(tesp_pkg::REQ_STOP, AXIS_Y, CH_A, 1'b0, 1'b0, '0, '0);
    issue_request(tesp_pkg::REQ_TICK, AXIS_Y, CH_B, 1'b0, 1'b0, '0, '0);    // disarmed by stop
    // both axes in one move; Y lands on a half step, truncated toward zero
    issue_request(tesp_pkg::REQ_MOVE, AXIS_X, CH_A, 1'b1, 1'b1, 24'sd16, -24'sd8);
    issue_request(tesp_pkg::REQ_TICK, AXIS_Y, CH_B, 1'b0, 1'b0, '0, '0);
    issue_request(tesp_pkg::REQ_TICK, AXIS_Y, CH_A, 1'b0, 1'b0, '0, '0);
    issue_request(tesp_pkg::REQ_TICK, AXIS_Y, CH_B, 1'b0, 1'b0, '0, '0);
    issue_request(tesp_pkg::REQ_TICK, AXIS_X, CH_A, 1'b0, 1'b0, '0, '0);
    issue_request(tesp_pkg::REQ_STOP, AXIS_X, CH_A, 1'b0, 1'b0, '0, '0);
    // all-ones offsets: X at a positive position steps back one, Y truncates to no motion
    issue_request(tesp_pkg::REQ_MOVE, AXIS_Y, CH_B, 1'b1, 1'b1, 24'shFFFFFF, 24'shFFFFFF);
    issue_request(tesp_pkg::REQ_MOVE, AXIS_X, CH_A, 1'b0, 1'b0, 24'sh123456, 24'sh654321);
  endtask

  // One move, then mostly correct encoder ticks, at most 30, until the axes brake,
  // a few overshoot ticks, and a stop for anything still running.
  task automatic track_sequence();
    int   pick;
    int   k;
    logic ax;
    logic ch;
    pick = $urandom_range(2);
    issue_request(tesp_pkg::REQ_MOVE, coin(), coin(), pick != 1, pick != 0,
                  pick_dest(AXIS_X, x_spm), pick_dest(AXIS_Y, y_spm));
    for (k = 0; k < 30 && (axes[AXIS_X].moving || axes[AXIS_Y].moving); k++) begin
      if (axes[AXIS_X].moving && axes[AXIS_Y].moving) ax = coin();
      else ax = axes[AXIS_Y].moving ? AXIS_Y : AXIS_X;
      ch = (axes[ax].armed == tesp_pkg::ARM_B) ? CH_B : CH_A;
      if ($urandom_range(99) < 4)
        issue_request(tesp_pkg::REQ_STOP, ax, coin(), coin(), coin(),
                      tesp_pkg::DEST_W'($urandom), tesp_pkg::DEST_W'($urandom));
      else
        issue_request(tesp_pkg::REQ_TICK, ax, ($urandom_range(99) < 12) ? ~ch : ch,
                      coin(), coin(),
                      tesp_pkg::DEST_W'($urandom), tesp_pkg::DEST_W'($urandom));
    end
    repeat ($urandom_range(2)) begin
      ax = coin();
      issue_request(tesp_pkg::REQ_TICK, ax, (axes[ax].armed == tesp_pkg::ARM_B) ? CH_B : CH_A,
                    1'b0, 1'b0, '0, '0);
    end
    if (axes[AXIS_X].moving)
      issue_request(tesp_pkg::REQ_STOP, AXIS_X, coin(), 1'b0, 1'b0, '0, '0);
    if (axes[AXIS_Y].moving)
      issue_request(tesp_pkg::REQ_STOP, AXIS_Y, coin(), 1'b0, 1'b0, '0, '0);
  endtask

  // Register sweep: extremes, zeros, junk upper bits and random settings,
  // each with one of four idle/stall patterns.
  task automatic test_random_tracking();
    int start;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_settings(15'd0, 15'd1, 15'd1023, 15'd32767);
        1: load_settings(15'd1, 15'd1023, 15'd1, 15'd1);
        2: load_settings(15'd0, 15'd0, 15'd0, 15'd0);
        3: load_settings(15'd1, 15'($urandom_range(1023, 1)), 15'($urandom_range(1023, 1)),
                         15'($urandom_range(32767, 1)));
        4: load_settings(15'h7FFE, 15'h7C03, 15'h7C28, 15'd200);
        5: load_settings(15'h7FFF, 15'd80, 15'd80, 15'd32767);
        6: load_settings(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom));
        default: load_settings(15'd0, 15'd1023, 15'd1023, 15'd100);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      start = items_sent;
      while (items_sent - start < 100) begin
        if ($urandom_range(99) < 15)
          issue_request(2'($urandom_range(3)), coin(), coin(), coin(), coin(),
                        tesp_pkg::DEST_W'($urandom), tesp_pkg::DEST_W'($urandom));
        else
          track_sequence();
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------
  initial begin
    foreach (axes[i])
      axes[i] = '{pos: '0, goal: '0, moving: 1'b0, armed: tesp_pkg::ARM_NONE,
                  bridge: tesp_pkg::DRV_BRAKE};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_requests();
    test_random_tracking();
    drain_results();
    // wait past the input and axis state registers so any stray result is caught
    repeat (6) @(posedge clk_i);
    if (mismatches == 0 && status_expected_q.size() == 0)
      $display("two_axis_encoder_position_stop: match");
    else
      $display("two_axis_encoder_position_stop: mismatch");
    $finish;
  end

  // Watchdog: more than ten times the slowest expected run.
  initial begin
    #400_000;
    $display("two_axis_encoder_position_stop: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
src/tesp_pkg.sv
src/tesp_conv.sv
src/tesp_axis.sv
src/two_axis_encoder_position_stop.sv
tb/tb.sv
